### hdl/wdh_pkg.sv
// shared types and constants for the windowed displacement hysteresis block
package wdh_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SAMPLE_INTERVAL = 2'd0,
    CFG_TAKEOFF         = 2'd1,
    CFG_LANDING         = 2'd2
  } cfg_idx_t;

  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned TIME_BITS     = 32;
  localparam int unsigned DIST_BITS     = 16;

  // per-axis magnitude is clamped before squaring
  localparam int unsigned CLAMP_MAG = 65536;
  localparam int unsigned MAG_BITS  = 17;
  localparam int unsigned SQ_BITS   = 2 * MAG_BITS;
  localparam int unsigned SUM_BITS  = SQ_BITS + 1;
  localparam int unsigned THR_BITS  = 2 * DIST_BITS;

  localparam logic [TIME_BITS-1:0] SAMPLE_INTERVAL_RST = 32'd100;
  localparam logic [DIST_BITS-1:0] TAKEOFF_RST         = 16'd1000;
  localparam logic [DIST_BITS-1:0] LANDING_RST         = 16'd500;

endpackage

### hdl/wdh_if.sv
// channel interfaces: position input, flag result and configuration write
interface wdh_in_if #(parameter int POSITION_BITS = 20);
  import wdh_pkg::*;
  logic                            valid;
  logic                            ready;
  logic signed [POSITION_BITS-1:0] north_cm;
  logic signed [POSITION_BITS-1:0] east_cm;
  logic [TIME_BITS-1:0]            now_ms;
  modport source (output valid, north_cm, east_cm, now_ms, input ready);
  modport sink (input valid, north_cm, east_cm, now_ms, output ready);
endinterface

interface wdh_out_if;
  logic valid;
  logic ready;
  logic airborne;
  logic sample_taken;
  logic took_off;
  logic touched_down;
  modport source (output valid, airborne, sample_taken, took_off, touched_down, input ready);
  modport sink (input valid, airborne, sample_taken, took_off, touched_down, output ready);
endinterface

interface wdh_cfg_if;
  import wdh_pkg::*;
  logic                     valid;
  logic                     ready;
  cfg_idx_t                 index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/wdh_cell.sv
// one window cell: holds a north/east position and passes it on when a sample is taken
module wdh_cell #(
  parameter int POSITION_BITS = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            shift_en,
  input  logic signed [POSITION_BITS-1:0] north_in,
  input  logic signed [POSITION_BITS-1:0] east_in,
  output logic signed [POSITION_BITS-1:0] north_out,
  output logic signed [POSITION_BITS-1:0] east_out
);

  logic signed [POSITION_BITS-1:0] north_r, north_nxt;
  logic signed [POSITION_BITS-1:0] east_r, east_nxt;

  always_comb begin
    north_nxt = shift_en ? north_in : north_r;
    east_nxt  = shift_en ? east_in  : east_r;
  end

  // window starts from the origin
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      north_r <= '0;
      east_r  <= '0;
    end else begin
      north_r <= north_nxt;
      east_r  <= east_nxt;
    end
  end

  assign north_out = north_r;
  assign east_out  = east_r;

endmodule

### hdl/windowed_displacement_hysteresis_core.sv
// Airborne/landed detector on windowed displacement. Every input transaction gives
// exactly one result transaction, in order. An item is taken as a sample when at least
// sample_interval ms (wrapping 32-bit time) have passed since the last taken sample;
// a taken sample shifts into a line of WINDOW_DEPTH-1 cells, reset to the origin, and
// is compared with the cell at the far end, the oldest position in the window. The
// flag goes airborne above takeoff_distance and landed below landing_distance, tested
// on squared centimetres with each axis clamped to 65536. One item per cycle is taken
// while the output does not stall; a result passes through a magnitude stage, a
// squaring stage and a sum-and-compare stage into the output register. Each
// stage holds its data under back-pressure, so up to three items are buffered while
// the output stalls. Write configuration only while no transaction is in flight.
module windowed_displacement_hysteresis_core #(
  parameter int WINDOW_DEPTH  = 32,
  parameter int POSITION_BITS = 20
) (
  input logic       clk,
  input logic       rst_n,
  wdh_in_if.sink    in_ch,
  wdh_out_if.source out_ch,
  wdh_cfg_if.sink   cfg_ch
);
  import wdh_pkg::*;

  localparam int NCELL  = WINDOW_DEPTH - 1;
  localparam int DIFF_W = POSITION_BITS + 1;
  localparam int EXT_W  = (DIFF_W > MAG_BITS) ? DIFF_W : MAG_BITS;

  function automatic logic [MAG_BITS-1:0] clamp_mag(input logic signed [DIFF_W-1:0] d);
    logic [DIFF_W-1:0] m;
    logic [EXT_W-1:0]  ext;
    m   = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    ext = EXT_W'(m);
    return (ext > EXT_W'(CLAMP_MAG)) ? MAG_BITS'(CLAMP_MAG) : ext[MAG_BITS-1:0];
  endfunction

  // configuration
  logic [TIME_BITS-1:0] interval_r, interval_nxt;
  logic [DIST_BITS-1:0] takeoff_r, takeoff_nxt;
  logic [DIST_BITS-1:0] landing_r, landing_nxt;
  logic [THR_BITS-1:0]  t2_r, l2_r;

  // pipeline control
  logic v1_r, v1_nxt, v2_r, v2_nxt, vo_r, vo_nxt;
  logic ready_o, ready2, ready1, in_acc, mv1, mv2;

  // sampler state
  logic [TIME_BITS-1:0] last_ms_r, last_ms_nxt;
  logic [TIME_BITS-1:0] elapsed;
  logic                 taken;
  logic                 air_r, air_nxt;

  // window line
  logic signed [POSITION_BITS-1:0] line_n [NCELL+1];
  logic signed [POSITION_BITS-1:0] line_e [NCELL+1];
  logic signed [DIFF_W-1:0]        diff_n, diff_e;

  // stage payloads
  logic                taken1_r, taken2_r;
  logic [MAG_BITS-1:0] mag_n_r, mag_e_r;
  logic [SQ_BITS-1:0]  sq_n_r, sq_e_r;
  logic [SUM_BITS-1:0] d2;
  logic                up, down;
  logic                o_air_r, o_taken_r, o_up_r, o_down_r;

  // handshake chain, each stage fills when the one after it is free or moving
  always_comb begin
    ready_o = !vo_r || out_ch.ready;
    mv2     = v2_r && ready_o;
    ready2  = !v2_r || ready_o;
    mv1     = v1_r && ready2;
    ready1  = !v1_r || ready2;
    in_acc  = in_ch.valid && ready1;
    v1_nxt  = in_acc ? 1'b1 : (mv1 ? 1'b0 : v1_r);
    v2_nxt  = mv1 ? 1'b1 : (mv2 ? 1'b0 : v2_r);
    vo_nxt  = mv2 ? 1'b1 : ((vo_r && out_ch.ready) ? 1'b0 : vo_r);
  end

  assign in_ch.ready  = ready1;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    interval_nxt = interval_r;
    takeoff_nxt  = takeoff_r;
    landing_nxt  = landing_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_SAMPLE_INTERVAL: interval_nxt = cfg_ch.data[TIME_BITS-1:0];
        CFG_TAKEOFF:         takeoff_nxt  = cfg_ch.data[DIST_BITS-1:0];
        CFG_LANDING:         landing_nxt  = cfg_ch.data[DIST_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sample gate
  always_comb begin
    elapsed     = in_ch.now_ms - last_ms_r;
    taken       = (elapsed >= interval_r);
    last_ms_nxt = (in_acc && taken) ? in_ch.now_ms : last_ms_r;
  end

  assign line_n[0] = in_ch.north_cm;
  assign line_e[0] = in_ch.east_cm;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    wdh_cell #(.POSITION_BITS(POSITION_BITS)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (in_acc && taken),
      .north_in (line_n[k]),
      .east_in  (line_e[k]),
      .north_out(line_n[k+1]),
      .east_out (line_e[k+1])
    );
  end

  // newest sample against the far end of the line, before it shifts
  always_comb begin
    diff_n = DIFF_W'(in_ch.north_cm) - DIFF_W'(line_n[NCELL]);
    diff_e = DIFF_W'(in_ch.east_cm) - DIFF_W'(line_e[NCELL]);
  end

  always_comb begin
    d2      = SUM_BITS'(sq_n_r) + SUM_BITS'(sq_e_r);
    up      = taken2_r && !air_r && (d2 > SUM_BITS'(t2_r));
    down    = taken2_r && air_r && (d2 < SUM_BITS'(l2_r));
    air_nxt = air_r;
    if (mv2 && (up || down)) begin
      air_nxt = up;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= SAMPLE_INTERVAL_RST;
      takeoff_r  <= TAKEOFF_RST;
      landing_r  <= LANDING_RST;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      vo_r       <= 1'b0;
      last_ms_r  <= '0;
      air_r      <= 1'b0;
    end else begin
      interval_r <= interval_nxt;
      takeoff_r  <= takeoff_nxt;
      landing_r  <= landing_nxt;
      v1_r       <= v1_nxt;
      v2_r       <= v2_nxt;
      vo_r       <= vo_nxt;
      last_ms_r  <= last_ms_nxt;
      air_r      <= air_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t2_r <= THR_BITS'(takeoff_r) * THR_BITS'(takeoff_r);
    l2_r <= THR_BITS'(landing_r) * THR_BITS'(landing_r);
    if (in_acc) begin
      taken1_r <= taken;
      mag_n_r  <= clamp_mag(diff_n);
      mag_e_r  <= clamp_mag(diff_e);
    end
    if (mv1) begin
      taken2_r <= taken1_r;
      sq_n_r   <= SQ_BITS'(mag_n_r) * SQ_BITS'(mag_n_r);
      sq_e_r   <= SQ_BITS'(mag_e_r) * SQ_BITS'(mag_e_r);
    end
    if (mv2) begin
      o_air_r   <= air_nxt;
      o_taken_r <= taken2_r;
      o_up_r    <= up;
      o_down_r  <= down;
    end
  end

  assign out_ch.valid        = vo_r;
  assign out_ch.airborne     = o_air_r;
  assign out_ch.sample_taken = o_taken_r;
  assign out_ch.took_off     = o_up_r;
  assign out_ch.touched_down = o_down_r;

  a_edge_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r |-> !(o_up_r && o_down_r))
    else $error("took_off and touched_down both set");

  a_edge_needs_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (vo_r && (o_up_r || o_down_r)) |-> (o_taken_r && (o_air_r == o_up_r)))
    else $error("flag edge without a taken sample or with the wrong flag");

  a_flag_moves_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(air_r) |-> (!$past(rst_n) || ($past(mv2) && $past(taken2_r))))
    else $error("airborne state changed outside a taken result");

  a_time_moves_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(last_ms_r) |-> (!$past(rst_n) || ($past(in_acc) && $past(taken))))
    else $error("last sample time changed without a taken transaction");

endmodule
